>>> sv/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg: shared definitions for the integer field formatter
// Conversion kinds, character codes, sizing constants and the digit table.
// ----------------------------------------------------------------------------
package ifmt_pkg;

   // Argument width and field limits
   localparam int VALUE_BITS = 32;
   localparam int MAX_FIELD  = 62;

   // Digit store sized for octal, the longest of the three radixes
   localparam int DIG_COUNT = (VALUE_BITS + 2) / 3;
   localparam int DIG_W     = 4 * DIG_COUNT;
   localparam int OCT_W     = 3 * DIG_COUNT;
   localparam int LEN_W     = $clog2(DIG_COUNT + 1);
   localparam int CNT_W     = $clog2(MAX_FIELD + 1);
   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);

   // Conversion kinds
   localparam logic [2:0] KIND_SDEC = 3'd0;
   localparam logic [2:0] KIND_UDEC = 3'd1;
   localparam logic [2:0] KIND_OCT  = 3'd2;
   localparam logic [2:0] KIND_HEX  = 3'd3;
   localparam logic [2:0] KIND_CHAR = 3'd4;

   // Character codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Lower-case digit characters
   localparam logic [7:0] DIGIT_CHARS [0:15] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_NORM = 5'b00100,
      ST_PLAN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

endpackage

>>> sv/integer_field_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_field_formatter_core: printf-style integer conversion
// Formats one value per request and streams the ASCII text one character
// per response, flagging the final character.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): value, kind, flags, width and precision. A
//   request is taken when req_valid is high and req_stall low. The block
//   works on one request at a time and holds req_stall high until the last
//   character has been loaded into the response register.
//   Response channel (rsp_*): one character per response, rsp_last_char on
//   the final one. Every request of a defined kind gives at least one
//   character; kinds 5..7 are taken and dropped without a response.
// Steps per request:
//   decimal kinds: bit-serial binary to BCD by the shift-and-add-3 loop,
//   then stripping leading zero digits, planning, and emitting the
//   characters (up to 63), one per cycle unless the response stalls.
//   octal and hex skip the BCD loop; a character goes straight to planning.
// A stalled response holds in the output register and pauses the character
// sequencer. Reset (synchronous, active high) returns to idle and drops any
// pending response.
// ----------------------------------------------------------------------------
module integer_field_formatter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_type,
   input  logic [31:0]       req_value,
   input  logic              req_flag_left,
   input  logic              req_flag_plus,
   input  logic              req_flag_space,
   input  logic              req_flag_zero,
   input  logic signed [6:0] req_field_width,
   input  logic              req_width_given,
   input  logic [5:0]        req_min_digits,
   input  logic              req_precision_given,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last_char
);
   import ifmt_pkg::*;

   // Registers
   state_type              state_ff, state_in;
   logic                   is_char_ff, is_char_in;
   logic                   left_ff, left_in;
   logic                   zero_ff, zero_in;
   logic                   sign_on_ff, sign_on_in;
   logic [7:0]             sign_char_ff, sign_char_in;
   logic [7:0]             char_ff, char_in;
   logic [CNT_W-1:0]       w_ff, w_in;
   logic [CNT_W-1:0]       p_ff, p_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [DIG_W-1:0]       dig_ff, dig_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [CNT_W-1:0]       pre_ff, pre_in;
   logic [CNT_W-1:0]       zeros_ff, zeros_in;
   logic [CNT_W-1:0]       post_ff, post_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Request side decode
   logic                   req_accept;
   logic                   kind_ok;
   logic [VALUE_BITS-1:0]  v_arg;
   logic                   v_neg;
   logic [VALUE_BITS-1:0]  v_mag;
   logic                   w_neg;
   logic [6:0]             w_mag;
   logic [OCT_W-1:0]       oct_ext;
   logic [DIG_W-1:0]       oct_dig;

   // Serial conversion and planning
   logic [DIG_W-1:0]       bcd_adj;
   logic [3:0]             top_dig;
   logic                   top_zero;
   logic [CNT_W-1:0]       len_c;
   logic                   p_gt;
   logic [CNT_W-1:0]       n_dig;
   logic [CNT_W:0]         n_all;
   logic [CNT_W:0]         w_ext;
   logic [CNT_W-1:0]       pad;
   logic [CNT_W-1:0]       zprec;
   logic [CNT_W-1:0]       zpad;
   logic [CNT_W:0]         zeros_sum;

   // Emission
   logic                   out_free;
   logic                   rest_digits, rest_zeros, rest_sign, rest_pre;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign kind_ok    = (req_type <= KIND_CHAR);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   // Argument magnitude and sign
   assign v_arg = VALUE_BITS'(req_value);
   assign v_neg = (req_type == KIND_SDEC) && v_arg[VALUE_BITS-1];
   assign v_mag = v_neg ? (~v_arg + VALUE_BITS'(1)) : v_arg;

   // Width magnitude; a negative width means left justify
   assign w_neg = req_width_given && req_field_width[6];
   always_comb begin
      if (!req_width_given) begin
         w_mag = 7'd0;
      end else if (w_neg) begin
         w_mag = ~7'(req_field_width) + 7'd1;
      end else begin
         w_mag = 7'(req_field_width);
      end
   end

   // Octal digits wired straight into nibbles
   assign oct_ext = OCT_W'(v_mag);
   always_comb begin
      for (int i = 0; i < DIG_COUNT; i++) begin
         oct_dig[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
      end
   end

   // Add-3 correction on each BCD digit before the shift
   always_comb begin
      for (int i = 0; i < DIG_COUNT; i++) begin
         if (dig_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = dig_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = dig_ff[4*i +: 4];
         end
      end
   end

   assign top_dig  = dig_ff[DIG_W-1 -: 4];
   assign top_zero = (top_dig == 4'd0);

   // Field planning: digit count, padding and run lengths
   assign len_c = CNT_W'(len_ff);
   assign p_gt  = (p_ff > len_c);
   always_comb begin
      if (is_char_ff) begin
         n_dig = CNT_W'(1);
      end else if (p_gt) begin
         n_dig = p_ff;
      end else if ((p_ff == '0) && (len_ff == LEN_W'(1)) && top_zero) begin
         n_dig = '0;   // zero value with zero precision counts as empty
      end else begin
         n_dig = len_c;
      end
   end
   assign n_all = {1'b0, n_dig} + (CNT_W+1)'(sign_on_ff);
   assign w_ext = {1'b0, w_ff};
   assign pad   = (w_ext > n_all) ? CNT_W'(w_ext - n_all) : '0;
   assign zprec = (!is_char_ff && p_gt) ? (p_ff - len_c) : '0;
   assign zpad  = (!left_ff && zero_ff) ? pad : '0;
   assign zeros_sum = {1'b0, zprec} + {1'b0, zpad};

   // Is everything after a run empty
   assign rest_digits = (post_ff == '0);
   assign rest_zeros  = (len_ff == '0) && rest_digits;
   assign rest_sign   = (zeros_ff == '0) && rest_zeros;
   assign rest_pre    = !sign_on_ff && rest_sign;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      is_char_in   = is_char_ff;
      left_in      = left_ff;
      zero_in      = zero_ff;
      sign_on_in   = sign_on_ff;
      sign_char_in = sign_char_ff;
      char_in      = char_ff;
      w_in         = w_ff;
      p_in         = p_ff;
      mag_in       = mag_ff;
      dig_in       = dig_ff;
      bit_cnt_in   = bit_cnt_ff;
      len_in       = len_ff;
      pre_in       = pre_ff;
      zeros_in     = zeros_ff;
      post_in      = post_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && kind_ok) begin
               is_char_in = (req_type == KIND_CHAR);
               left_in    = req_flag_left || w_neg;
               zero_in    = req_flag_zero && !req_precision_given &&
                            (req_type != KIND_CHAR);
               char_in    = req_value[7:0];
               w_in       = (w_mag > 7'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(w_mag);
               if (!req_precision_given) begin
                  p_in = CNT_W'(1);
               end else if (CNT_W'(req_min_digits) > CNT_W'(MAX_FIELD)) begin
                  p_in = CNT_W'(MAX_FIELD);
               end else begin
                  p_in = CNT_W'(req_min_digits);
               end
               // sign position
               if (req_type == KIND_CHAR) begin
                  sign_on_in   = 1'b0;
                  sign_char_in = CH_SPACE;
               end else if (v_neg) begin
                  sign_on_in   = 1'b1;
                  sign_char_in = CH_MINUS;
               end else if (req_flag_plus) begin
                  sign_on_in   = 1'b1;
                  sign_char_in = CH_PLUS;
               end else begin
                  sign_on_in   = req_flag_space;
                  sign_char_in = CH_SPACE;
               end
               mag_in     = v_mag;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS);
               len_in     = LEN_W'(DIG_COUNT);
               unique case (req_type)
                  KIND_OCT: begin
                     dig_in   = oct_dig;
                     state_in = ST_NORM;
                  end
                  KIND_HEX: begin
                     dig_in   = DIG_W'(v_mag);
                     state_in = ST_NORM;
                  end
                  KIND_CHAR: begin
                     dig_in   = '0;
                     len_in   = LEN_W'(1);
                     state_in = ST_PLAN;
                  end
                  default: begin
                     dig_in   = '0;
                     state_in = ST_CONV;
                  end
               endcase
            end
         end

         // One binary bit into the BCD register per cycle
         ST_CONV: begin
            dig_in     = {bcd_adj[DIG_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               state_in = ST_NORM;
            end
         end

         // Strip leading zero digits, keeping at least one
         ST_NORM: begin
            if ((len_ff > LEN_W'(1)) && top_zero) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               len_in = len_ff - LEN_W'(1);
            end else begin
               state_in = ST_PLAN;
            end
         end

         ST_PLAN: begin
            pre_in   = (!left_ff && !zero_ff) ? pad : '0;
            zeros_in = CNT_W'(zeros_sum);
            post_in  = left_ff ? pad : '0;
            state_in = ST_EMIT;
         end

         // One character per cycle while the response is not stalled, runs in output order
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               priority if (pre_ff != '0) begin
                  rsp_char_in = CH_SPACE;
                  rsp_last_in = (pre_ff == CNT_W'(1)) && rest_pre;
                  pre_in      = pre_ff - CNT_W'(1);
               end else if (sign_on_ff) begin
                  rsp_char_in = sign_char_ff;
                  rsp_last_in = rest_sign;
                  sign_on_in  = 1'b0;
               end else if (zeros_ff != '0) begin
                  rsp_char_in = CH_ZERO;
                  rsp_last_in = (zeros_ff == CNT_W'(1)) && rest_zeros;
                  zeros_in    = zeros_ff - CNT_W'(1);
               end else if (len_ff != '0) begin
                  rsp_char_in = is_char_ff ? char_ff : DIGIT_CHARS[top_dig];
                  rsp_last_in = (len_ff == LEN_W'(1)) && rest_digits;
                  len_in      = len_ff - LEN_W'(1);
                  dig_in      = {dig_ff[DIG_W-5:0], 4'd0};
               end else begin
                  rsp_char_in = CH_SPACE;
                  rsp_last_in = (post_ff <= CNT_W'(1));
                  post_in     = post_ff - CNT_W'(1);
               end
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      is_char_ff   <= is_char_in;
      left_ff      <= left_in;
      zero_ff      <= zero_in;
      sign_on_ff   <= sign_on_in;
      sign_char_ff <= sign_char_in;
      char_ff      <= char_in;
      w_ff         <= w_in;
      p_ff         <= p_in;
      mag_ff       <= mag_in;
      dig_ff       <= dig_in;
      bit_cnt_ff   <= bit_cnt_in;
      len_ff       <= len_in;
      pre_ff       <= pre_in;
      zeros_ff     <= zeros_in;
      post_ff      <= post_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

>>> sv/ifmt_checker.sv
// ----------------------------------------------------------------------------
// ifmt_checker: port-level checks for the integer field formatter
// Watches the request and response channels and is bound to the core.
// ----------------------------------------------------------------------------
module ifmt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [2:0]        req_type,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [7:0]        rsp_out_char,
   input logic              rsp_last_char
);
   import ifmt_pkg::*;

   // A stalled response holds its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char) &&
                                 $stable(rsp_last_char))
      else $error("stalled response changed");

   // A request of a defined kind makes the block busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type <= KIND_CHAR) |=> req_stall)
      else $error("block not busy after a request");

   // The block frees up only when the final character is presented
   a_free_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid && rsp_last_char)
      else $error("block freed without a final character");

   // An idle block can only be holding the final character of a request
   a_idle_holds_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !req_stall |-> rsp_last_char)
      else $error("idle block holds a character that is not final");

endmodule

bind integer_field_formatter_core ifmt_checker u_ifmt_checker (.*);
